// ----- src/spcr_pkg.sv -----
package spcr_pkg;

	localparam int PACKET_LENGTH = 18;
	localparam int COUNT_W = 6;
	localparam int KEPT_BYTES = 7;
	localparam int NUM_CHANNELS = 6;
	localparam int BYTE_W = 8;
	localparam int PULSE_W = 11;
	localparam int FLAGS_W = 3;
	localparam int OUT_FIELDS_W = BYTE_W + NUM_CHANNELS * PULSE_W;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W = OUT_DATA_W - OUT_FIELDS_W;
	localparam int KEPT_IDX_W = $clog2(KEPT_BYTES);

	localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(PACKET_LENGTH - 1);
	localparam logic [COUNT_W-1:0] KEPT_COUNT = COUNT_W'(KEPT_BYTES);

	localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;

	// x*1000/255 as one multiply by a scaled reciprocal, exact for all 8-bit x
	localparam int SCALE_PROD_W = 37;
	localparam logic [SCALE_PROD_W-1:0] SCALE_MULT = 37'd263173000;
	localparam int SCALE_SHIFT = 26;

	localparam logic [BYTE_W-1:0] MAGIC_RESET = 8'd110;
	localparam logic [BYTE_W-1:0] REQUEST_RESET = 8'd251;
	localparam logic [BYTE_W-1:0] ACCEPT_RESET = 8'd252;
	localparam logic [BYTE_W-1:0] REJECT_RESET = 8'd145;

	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MAGIC,
		REG_REQUEST,
		REG_ACCEPT,
		REG_REJECT
	} reg_index_t;

	// packet byte feeding each channel: throttle, yaw, pitch, roll, aux one, aux two
	localparam logic [KEPT_IDX_W-1:0] CHAN_SRC [NUM_CHANNELS] = '{
		3'd1, 3'd4, 3'd2, 3'd3, 3'd5, 3'd6
	};

	typedef struct packed {
		logic [BYTE_W-1:0] packet_magic;
		logic [BYTE_W-1:0] request_code;
		logic [BYTE_W-1:0] accept_code;
		logic [BYTE_W-1:0] reject_code;
	} cfg_t;

	typedef struct packed {
		logic [NUM_CHANNELS-1:0][PULSE_W-1:0] pulse;
		logic [BYTE_W-1:0] reply_byte;
		logic packet_ok;
		logic packet_done;
		logic reply_loaded;
	} result_t;

	function automatic logic [PULSE_W-1:0] scale_pulse(logic [BYTE_W-1:0] x);
		logic [SCALE_PROD_W-1:0] prod;
		prod = SCALE_PROD_W'(x) * SCALE_MULT;
		return PULSE_MIN + PULSE_W'(prod >> SCALE_SHIFT);
	endfunction

endpackage

// ----- src/spcr_cfg.sv -----
module spcr_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [spcr_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [spcr_pkg::BYTE_W-1:0]           cfg_data,
	output spcr_pkg::cfg_t                        cfg
);

	spcr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.packet_magic <= spcr_pkg::MAGIC_RESET;
			cfg_q.request_code <= spcr_pkg::REQUEST_RESET;
			cfg_q.accept_code <= spcr_pkg::ACCEPT_RESET;
			cfg_q.reject_code <= spcr_pkg::REJECT_RESET;
		end else if (cfg_we) begin
			case (spcr_pkg::reg_index_t'(cfg_index))
				spcr_pkg::REG_MAGIC: cfg_q.packet_magic <= cfg_data;
				spcr_pkg::REG_REQUEST: cfg_q.request_code <= cfg_data;
				spcr_pkg::REG_ACCEPT: cfg_q.accept_code <= cfg_data;
				spcr_pkg::REG_REJECT: cfg_q.reject_code <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/spcr_core.sv -----
module spcr_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [spcr_pkg::BYTE_W-1:0]  rx_byte,
	input  spcr_pkg::cfg_t               cfg,
	output spcr_pkg::result_t            res
);

	logic                                collecting_q;
	logic                                collecting_d;
	logic [spcr_pkg::COUNT_W-1:0]        count_q;
	logic [spcr_pkg::COUNT_W-1:0]        count_d;
	logic [spcr_pkg::BYTE_W-1:0]         bytes_q [spcr_pkg::KEPT_BYTES];
	logic [spcr_pkg::NUM_CHANNELS-1:0][spcr_pkg::PULSE_W-1:0] pulse_q;
	logic [spcr_pkg::NUM_CHANNELS-1:0][spcr_pkg::PULSE_W-1:0] pulse_d;
	logic [spcr_pkg::NUM_CHANNELS-1:0][spcr_pkg::PULSE_W-1:0] scaled;
	logic                                store_en;

	always_comb begin
		for (int i = 0; i < spcr_pkg::NUM_CHANNELS; i++) begin
			scaled[i] = spcr_pkg::scale_pulse(bytes_q[spcr_pkg::CHAN_SRC[i]]);
		end
	end

	always_comb begin
		collecting_d = collecting_q;
		count_d = count_q;
		pulse_d = pulse_q;
		store_en = 1'b0;
		res.reply_byte = '0;
		res.reply_loaded = 1'b0;
		res.packet_done = 1'b0;
		res.packet_ok = 1'b0;
		if (collecting_q) begin
			res.reply_loaded = 1'b1;
			if (count_q < spcr_pkg::LAST_COUNT) begin
				store_en = (count_q < spcr_pkg::KEPT_COUNT);
				count_d = count_q + 1'b1;
				res.reply_byte = spcr_pkg::BYTE_W'(count_d);
			end else begin
				collecting_d = 1'b0;
				res.packet_done = 1'b1;
				if (bytes_q[0] == cfg.packet_magic) begin
					res.packet_ok = 1'b1;
					pulse_d = scaled;
					res.reply_byte = cfg.accept_code;
				end else begin
					res.reply_byte = cfg.reject_code;
				end
			end
		end else if (rx_byte == cfg.request_code) begin
			collecting_d = 1'b1;
			count_d = '0;
		end
		res.pulse = pulse_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			count_q <= '0;
			for (int i = 0; i < spcr_pkg::NUM_CHANNELS; i++) begin
				pulse_q[i] <= spcr_pkg::PULSE_MIN;
			end
		end else if (fire) begin
			collecting_q <= collecting_d;
			count_q <= count_d;
			pulse_q <= pulse_d;
		end
	end

	// packet bytes hold no reset value: byte 0 is always written before it is checked
	always_ff @(posedge clk) begin
		if (fire && store_en) begin
			bytes_q[count_q[spcr_pkg::KEPT_IDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

// ----- src/spi_control_packet_receiver.sv -----
// channel   dir  fields
// s_axis    in   tdata[7:0] rx_byte
// m_axis    out  tdata: reply_byte, six pulse widths; tuser: loaded, done, ok
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// one transaction in gives one transaction out, one byte per cycle sustained while m_axis is ready
// a byte passes through an input register, then the result register
// the packet state advances as a byte moves from the input to the result register
// m_axis stalls hold the result; the input register still takes one more byte
// reset clears the state and valid flags, sets the held pulse widths to 1000 and the cfg registers to defaults
module spi_control_packet_receiver (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// [7:0] rx_byte
	input  logic [spcr_pkg::BYTE_W-1:0]             s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// [7:0] reply_byte, [18:8] throttle_pulse, [29:19] yaw_pulse, [40:30] pitch_pulse,
	// [51:41] roll_pulse, [62:52] aux_one_pulse, [73:63] aux_two_pulse, rest zero
	output logic [spcr_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	// [0] reply_loaded, [1] packet_done, [2] packet_ok
	output logic [spcr_pkg::FLAGS_W-1:0]            m_axis_tuser,
	input  logic                                    cfg_we,
	input  logic [spcr_pkg::REG_IDX_W-1:0]          cfg_index,
	input  logic [spcr_pkg::BYTE_W-1:0]             cfg_data
);

	logic                            valid_s1;
	logic [spcr_pkg::BYTE_W-1:0]     byte_s1;
	logic                            out_valid_q;
	spcr_pkg::result_t               res;
	spcr_pkg::result_t               res_q;
	spcr_pkg::cfg_t                  cfg;
	logic                            fire;

	assign fire = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;

	spcr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spcr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{spcr_pkg::OUT_PAD_W{1'b0}}, res_q.pulse, res_q.reply_byte};
	assign m_axis_tuser = {res_q.packet_ok, res_q.packet_done, res_q.reply_loaded};

endmodule
